// ===== rtl/core/lexc_pkg.sv =====
// Shared types, character classes and keyword constants for the token classifier.
package lexc_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [2:0] token_class;
    logic [7:0] token_length;
  } out_item_t;

  localparam logic [2:0] CLS_KEYWORD    = 3'd0;
  localparam logic [2:0] CLS_IDENTIFIER = 3'd1;
  localparam logic [2:0] CLS_FUNCTION   = 3'd2;
  localparam logic [2:0] CLS_OPERATOR   = 3'd3;
  localparam logic [2:0] CLS_NUMBER     = 3'd4;
  localparam logic [2:0] CLS_ERROR      = 3'd5;

  localparam int unsigned NUM_KW  = 6;
  localparam int unsigned KW_MAXW = 6;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;

  // Keyword spellings, unused positions padded with zero.
  localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAXW] = '{
    '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},  // int
    '{8'h64, 8'h6F, 8'h75, 8'h62, 8'h6C, 8'h65},  // double
    '{8'h66, 8'h6C, 8'h6F, 8'h61, 8'h74, 8'h00},  // float
    '{8'h73, 8'h74, 8'h72, 8'h69, 8'h6E, 8'h67},  // string
    '{8'h63, 8'h68, 8'h61, 8'h72, 8'h00, 8'h00},  // char
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E}   // return
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd6, 3'd5, 3'd6, 3'd4, 3'd6};

  function automatic logic [7:0] kw_char(input int unsigned k, input logic [2:0] p);
    logic [7:0] c;
    c = 8'h00;
    if (p < 3'(KW_MAXW)) begin
      c = KW_TEXT[k][p];
    end
    return c;
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_word_start(input logic [7:0] c);
    return (c == CH_UNDERSCORE) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) || (c == 8'h2F) ||
           (c == 8'h3D) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
           (c == 8'h7B) || (c == 8'h7D) || (c == 8'h2C) || (c == 8'h3B);
  endfunction

endpackage

// ===== rtl/core/lexc_core.sv =====
// Per-token flag registers and the classification of a closing token.
module lexc_core #(
  parameter int unsigned LENGTH_LIMIT = 255
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  lexc_pkg::in_item_t  item,
  output logic                res_valid,
  output lexc_pkg::out_item_t res
);

  localparam int unsigned CW = $clog2(LENGTH_LIMIT + 1);
  localparam int unsigned LW = (CW > 8) ? CW : 8;

  logic [CW-1:0] count_r, count_nxt;
  logic [lexc_pkg::NUM_KW-1:0] cand_r, cand_nxt;
  logic          fcws_r, fcws_nxt;
  logic          word_r, word_nxt;
  logic          dec_r, dec_nxt;
  logic [1:0]    wph_r, wph_nxt;
  logic [1:0]    kph_r, kph_nxt;
  logic [15:0]   last2_r, last2_nxt;

  logic          close;
  logic          kw_exact;
  logic [7:0]    last_c, prev_c;
  logic [LW-1:0] count_ext;
  logic [7:0]    c;

  assign c      = item.text_byte;
  assign close  = item.end_of_text || lexc_pkg::is_sep(c);
  assign last_c = last2_r[7:0];
  assign prev_c = last2_r[15:8];

  always_comb begin
    kw_exact = 1'b0;
    for (int unsigned k = 0; k < lexc_pkg::NUM_KW; k++) begin
      if (cand_r[k] && (count_r == CW'(lexc_pkg::KW_LEN[k]))) begin
        kw_exact = 1'b1;
      end
    end
  end

  always_comb begin
    priority if (kw_exact) begin
      res.token_class = lexc_pkg::CLS_KEYWORD;
    end else if (fcws_r && word_r) begin
      res.token_class = lexc_pkg::CLS_IDENTIFIER;
    end else if ((count_r >= CW'(3)) && (prev_c == lexc_pkg::CH_LPAREN) &&
                 (last_c == lexc_pkg::CH_RPAREN) && fcws_r && wph_r[1] && !kph_r[1]) begin
      res.token_class = lexc_pkg::CLS_FUNCTION;
    end else if ((count_r == CW'(1)) && lexc_pkg::is_op(last_c)) begin
      res.token_class = lexc_pkg::CLS_OPERATOR;
    end else if (dec_r) begin
      res.token_class = lexc_pkg::CLS_NUMBER;
    end else begin
      res.token_class = lexc_pkg::CLS_ERROR;
    end
  end

  assign count_ext        = LW'(count_r);
  assign res.token_length = (count_ext > LW'(255)) ? 8'hFF : count_ext[7:0];
  assign res_valid        = close && (count_r != '0);

  always_comb begin
    count_nxt = count_r;
    cand_nxt  = cand_r;
    fcws_nxt  = fcws_r;
    word_nxt  = word_r;
    dec_nxt   = dec_r;
    wph_nxt   = wph_r;
    kph_nxt   = kph_r;
    last2_nxt = last2_r;
    if (close) begin
      count_nxt = '0;
      cand_nxt  = '1;
      fcws_nxt  = 1'b0;
      word_nxt  = 1'b1;
      dec_nxt   = 1'b1;
      wph_nxt   = 2'b00;
      kph_nxt   = 2'b00;
      last2_nxt = 16'h0000;
    end else begin
      // History bits describe the token before this character joins it.
      wph_nxt = {wph_r[0], word_r};
      kph_nxt = {kph_r[0], kw_exact};
      for (int unsigned k = 0; k < lexc_pkg::NUM_KW; k++) begin
        if (!((count_r < CW'(lexc_pkg::KW_LEN[k])) &&
              (lexc_pkg::kw_char(k, count_r[2:0]) == c))) begin
          cand_nxt[k] = 1'b0;
        end
      end
      if (count_r == '0) begin
        fcws_nxt = lexc_pkg::is_word_start(c);
      end
      if (!(lexc_pkg::is_word_start(c) || lexc_pkg::is_digit(c))) begin
        word_nxt = 1'b0;
      end
      if (!lexc_pkg::is_digit(c)) begin
        dec_nxt = 1'b0;
      end
      last2_nxt = {last2_r[7:0], c};
      if (count_r < CW'(LENGTH_LIMIT)) begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cand_r  <= '1;
      fcws_r  <= 1'b0;
      word_r  <= 1'b1;
      dec_r   <= 1'b1;
      wph_r   <= 2'b00;
      kph_r   <= 2'b00;
      last2_r <= 16'h0000;
    end else if (step) begin
      count_r <= count_nxt;
      cand_r  <= cand_nxt;
      fcws_r  <= fcws_nxt;
      word_r  <= word_nxt;
      dec_r   <= dec_nxt;
      wph_r   <= wph_nxt;
      kph_r   <= kph_nxt;
      last2_r <= last2_nxt;
    end
  end

endmodule

// ===== rtl/core/lexical_token_classifier_unit.sv =====
// Top level of the token classifier: input register, classifier core, result register.
//
//   channel | ports                        | direction | payload
//   --------+------------------------------+-----------+----------------------------
//   input   | in_valid, in_ready, in_data  | in        | text_byte, end_of_text
//   result  | out_valid, out_ready, out_data | out     | token_class, token_length
//
// One character is taken per clock while the result is not stalled. The
// separator or end-of-text item that closes the token waits in the input
// register, and the result register loads as that item advances out of it.
// The input register advances whenever the result register is empty or is
// being emptied, so a stalled result holds the pipeline but nothing is lost.
// Reset is synchronous and clears both valid flags and the token state.
module lexical_token_classifier_unit #(
  parameter int unsigned LENGTH_LIMIT = 255
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lexc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lexc_pkg::out_item_t out_data
);

  logic                s0_valid_r;
  lexc_pkg::in_item_t  s0_data_r;
  logic                advance;
  logic                res_valid;
  lexc_pkg::out_item_t res;
  logic                out_valid_r;
  lexc_pkg::out_item_t out_data_r;

  assign advance  = s0_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s0_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_data_r <= in_data;
    end
  end

  lexc_core #(
    .LENGTH_LIMIT(LENGTH_LIMIT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (s0_data_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/lexc_checker.sv =====
// Port-level checks for the token classifier and their bind to the top level.
module lexc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input lexc_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input lexc_pkg::out_item_t out_data
);

  // A result waiting for transfer keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.token_length != 8'd0)
    else $error("result with empty token");

  // An input item waiting for transfer keeps its contents.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while stalled");

  // Operators are single characters.
  a_op_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token_class == lexc_pkg::CLS_OPERATOR
      |-> out_data.token_length == 8'd1)
    else $error("operator longer than one character");

  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind lexical_token_classifier_unit lexc_checker u_lexc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== verif/tb_lexical_token_classifier_unit.sv =====
// Self-checking testbench for the lexical token classifier with a built-in token predictor.
module tb_lexical_token_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_BYTES = 1100;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned TAIL_CYCLES  = 12;
  localparam int unsigned LEN_CAP      = 255;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  lexc_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lexc_pkg::out_item_t out_data;

  lexical_token_classifier_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  lexc_pkg::in_item_t  pending_bytes[$];
  lexc_pkg::out_item_t expected_tokens[$];
  int unsigned err_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned tokens_checked = 0;
  int unsigned class_count[6] = '{default: 0};
  int unsigned idle_cycles = 0;

  string keyword_words[6] = '{"int", "double", "float", "string", "char", "return"};

  // Running state of the token currently being collected.
  int unsigned tok_len = 0;
  logic [5:0]  kw_alive = 6'h3F;
  logic        starts_word = 1'b0;
  logic        word_only = 1'b1;
  logic        digits_only = 1'b1;
  logic [1:0]  word_hist = 2'b00;
  logic [1:0]  kw_hist = 2'b00;
  logic [15:0] tail_pair = 16'h0000;

  function automatic logic sep_char(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic digit_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic word_start_char(input logic [7:0] c);
    return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic op_char(input logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "=" || c == "(" ||
           c == ")" || c == "{" || c == "}" || c == "," || c == ";";
  endfunction

  function automatic logic token_is_keyword();
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < 6; k++) begin
      if (kw_alive[k] && tok_len == keyword_words[k].len()) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [2:0] closing_class();
    if (token_is_keyword()) return lexc_pkg::CLS_KEYWORD;
    if (starts_word && word_only) return lexc_pkg::CLS_IDENTIFIER;
    // A function needs a non-keyword identifier in front of a trailing "()".
    if (tok_len >= 3 && tail_pair == {8'h28, 8'h29} && starts_word && word_hist[1] &&
        !kw_hist[1]) return lexc_pkg::CLS_FUNCTION;
    if (tok_len == 1 && op_char(tail_pair[7:0])) return lexc_pkg::CLS_OPERATOR;
    if (digits_only) return lexc_pkg::CLS_NUMBER;
    return lexc_pkg::CLS_ERROR;
  endfunction

  // Advances the token state by one transfer; returns 1 when a token closes.
  function automatic logic predict_token(input lexc_pkg::in_item_t it,
                                         output lexc_pkg::out_item_t res);
    logic [7:0] c;
    string      w;
    c = it.text_byte;
    res = '0;
    if (it.end_of_text || sep_char(c)) begin
      if (tok_len == 0) return 1'b0;
      res.token_class  = closing_class();
      res.token_length = 8'((tok_len > LEN_CAP) ? LEN_CAP : tok_len);
      tok_len = 0;
      kw_alive = 6'h3F;
      starts_word = 1'b0;
      word_only = 1'b1;
      digits_only = 1'b1;
      word_hist = 2'b00;
      kw_hist = 2'b00;
      tail_pair = 16'h0000;
      return 1'b1;
    end
    word_hist = {word_hist[0], word_only};
    kw_hist   = {kw_hist[0], token_is_keyword()};
    for (int k = 0; k < 6; k++) begin
      w = keyword_words[k];
      if (!(tok_len < w.len() && w[tok_len] == c)) kw_alive[k] = 1'b0;
    end
    if (tok_len == 0) starts_word = word_start_char(c);
    if (!(word_start_char(c) || digit_char(c))) word_only = 1'b0;
    if (!digit_char(c)) digits_only = 1'b0;
    tail_pair = {tail_pair[7:0], c};
    if (tok_len < LEN_CAP) tok_len++;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- stimulus
  task automatic push_char(input logic [7:0] c);
    lexc_pkg::in_item_t it;
    it.text_byte = c;
    it.end_of_text = 1'b0;
    pending_bytes.push_back(it);
  endtask

  task automatic push_end();
    lexc_pkg::in_item_t it;
    it.text_byte = 8'($urandom);
    it.end_of_text = 1'b1;
    pending_bytes.push_back(it);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_break();
    logic [7:0] seps[6];
    seps = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    if ($urandom_range(0, 7) == 0) push_end();
    else push_char(seps[$urandom_range(0, 5)]);
    // Back-to-back separators close nothing.
    if ($urandom_range(0, 9) == 0) push_char(seps[$urandom_range(0, 5)]);
  endtask

  function automatic logic [7:0] rand_word_start();
    case ($urandom_range(0, 2))
      0: return 8'("a" + $urandom_range(0, 25));
      1: return 8'("A" + $urandom_range(0, 25));
      default: return "_";
    endcase
  endfunction

  function automatic logic [7:0] rand_word_char();
    if ($urandom_range(0, 3) == 0) return 8'("0" + $urandom_range(0, 9));
    return rand_word_start();
  endfunction

  function automatic logic [7:0] rand_op();
    string ops;
    ops = "+-*/=(){},;";
    return ops[$urandom_range(0, 10)];
  endfunction

  function automatic logic [7:0] rand_token_byte();
    logic [7:0] c;
    c = 8'($urandom);
    while (sep_char(c)) c = 8'($urandom);
    return c;
  endfunction

  task automatic push_ident(input int unsigned n);
    push_char(rand_word_start());
    for (int i = 1; i < n; i++) push_char(rand_word_char());
  endtask

  task automatic push_long_token();
    int unsigned n;
    int unsigned kind;
    n = $urandom_range(250, 300);
    kind = $urandom_range(0, 2);
    if (kind == 0) push_ident(n);
    if (kind == 1) for (int i = 0; i < n; i++) push_char(8'("0" + $urandom_range(0, 9)));
    if (kind == 2) begin
      push_ident(n);
      push_text("()");
    end
  endtask

  task automatic push_random_token();
    int unsigned pick;
    int unsigned sub;
    string       kw;
    pick = $urandom_range(0, 199);
    sub  = $urandom_range(0, 4);
    kw   = keyword_words[$urandom_range(0, 5)];
    if (pick == 0) begin
      push_long_token();
    end else if (pick < 26) begin
      push_text(kw);
    end else if (pick < 42) begin
      // Keyword prefixes and extensions must fall back to identifiers.
      if (sub < 2) push_text(kw.substr(0, $urandom_range(0, kw.len() - 2)));
      else begin
        push_text(kw);
        for (int i = $urandom_range(1, 3); i > 0; i--) push_char(rand_word_char());
      end
    end else if (pick < 80) begin
      push_ident($urandom_range(1, 10));
    end else if (pick < 104) begin
      case (sub)
        0, 1: push_ident($urandom_range(1, 8));
        2: push_text(kw);
        3: ;
        default: push_char(rand_token_byte());
      endcase
      if ($urandom_range(0, 3) == 0) push_char(rand_op());
      else push_text("()");
    end else if (pick < 124) begin
      push_char(rand_op());
      if (sub == 0) push_char(rand_word_char());
    end else if (pick < 148) begin
      for (int i = $urandom_range(1, 8); i > 0; i--) push_char(8'("0" + $urandom_range(0, 9)));
      if (sub == 0) push_char(rand_word_start());
      if (sub == 1) push_text("()");
    end else begin
      for (int i = $urandom_range(1, 8); i > 0; i--) begin
        case ($urandom_range(0, 2))
          0: push_char(rand_token_byte());
          1: push_char(rand_word_char());
          default: push_char(rand_op());
        endcase
      end
    end
  endtask

  task automatic build_stimulus();
    int unsigned target;
    // Directed part: each separator, each class but identifier, the paren corner cases,
    // odd bytes, and ends with nothing pending.
    push_text("int");   push_char(8'h09);
    push_text("f_1()"); push_char(8'h0A);
    push_text("()");    push_char(8'h0B);
    push_text("int()"); push_char(8'h0C);
    push_text("(");     push_char(8'h0D);
    push_text(")");     push_char(8'h20);
    push_text("+");     push_end();
    push_text("0123");  push_char(8'h20);
    push_char(8'h00);   push_char(8'hFF); push_char(8'h80); push_end();
    push_end();
    push_char(8'h20);
    target = pending_bytes.size() + RANDOM_BYTES;
    push_long_token();
    push_break();
    while (pending_bytes.size() < target) begin
      push_random_token();
      push_break();
    end
    push_text("x()");
    push_end();
  endtask

  // ------------------------------------------------------------------ driver
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    lexc_pkg::out_item_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        bytes_sent++;
        if (predict_token(in_data, res)) expected_tokens.push_back(res);
      end
      if (!in_valid || in_ready) begin
        if (burst_left != 0 && pending_bytes.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_bytes.pop_front();
          burst_left--;
        end else begin
          in_valid <= 1'b0;
          if (gap_left != 0) begin
            gap_left--;
          end else begin
            // Some bursts run long with no gap after them.
            burst_left = $urandom_range(1, 4) == 1 ? $urandom_range(60, 200) :
                         $urandom_range(1, 30);
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------- receiver stall
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned phase_ctr = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      phase_ctr++;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= phase_ctr[2];
      endcase
    end
  end

  // ----------------------------------------------------------------- monitor
  always @(posedge clk) begin
    lexc_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected transfer: token_class %0d token_length %0d",
               out_data.token_class, out_data.token_length);
        err_count++;
      end else begin
        want = expected_tokens.pop_front();
        tokens_checked++;
        if (want.token_class <= lexc_pkg::CLS_ERROR) class_count[want.token_class]++;
        if (out_data.token_class !== want.token_class) begin
          $error("token_class: expected %0d, actual %0d", want.token_class,
                 out_data.token_class);
          err_count++;
        end
        if (out_data.token_length !== want.token_length) begin
          $error("token_length: expected %0d, actual %0d", want.token_length,
                 out_data.token_length);
          err_count++;
        end
      end
    end
  end

  // Cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // --------------------------------------------------------------- sequence
  initial begin
    logic timed_out;
    timed_out = 1'b0;
    build_stimulus();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Checked between edges so the driver and monitor have settled.
    while (!timed_out &&
           !(pending_bytes.size() == 0 && !in_valid && expected_tokens.size() == 0)) begin
      @(negedge clk);
      timed_out = idle_cycles >= IDLE_LIMIT;
    end
    if (!timed_out) repeat (TAIL_CYCLES) @(posedge clk);
    if (timed_out) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, expected_tokens.size());
      $display("tb: failure");
    end else begin
      if (expected_tokens.size() != 0) begin
        $error("%0d expected results never arrived", expected_tokens.size());
        err_count++;
      end
      $display("summary: %0d bytes in, %0d tokens checked, %0d mismatches",
               bytes_sent, tokens_checked, err_count);
      $display("summary: keyword %0d identifier %0d function %0d operator %0d number %0d error %0d",
               class_count[lexc_pkg::CLS_KEYWORD], class_count[lexc_pkg::CLS_IDENTIFIER],
               class_count[lexc_pkg::CLS_FUNCTION], class_count[lexc_pkg::CLS_OPERATOR],
               class_count[lexc_pkg::CLS_NUMBER], class_count[lexc_pkg::CLS_ERROR]);
      if (err_count == 0) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
    end
    $finish;
  end

endmodule
